>>> hw/rtl/smc_pkg.sv
package smc_pkg;

    localparam int IDX_W            = 10;
    localparam int SAMPLE_W         = 16;
    localparam int SUM_W            = 24;
    localparam int CENT_W           = 17;
    localparam int CNT_W            = 9;

    localparam int DEF_MAX_POINTS   = 1024;
    localparam int MAX_SNAPSHOTS    = 256;
    localparam int CENT_LIMIT       = 65535;

    localparam logic ACTION_ACCUM   = 1'b0;
    localparam logic ACTION_CENTER  = 1'b1;

endpackage

>>> hw/rtl/smc_if.sv
interface smc_item_if import smc_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic                       first_snapshot;
    logic [IDX_W-1:0]           point_index;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, action, first_snapshot, point_index, sample, input ready);
    modport sink   (input valid, action, first_snapshot, point_index, sample, output ready);

endinterface

interface smc_result_if import smc_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [CENT_W-1:0] centered;
    logic [IDX_W-1:0]         out_point;

    modport source (output valid, centered, out_point, input ready);
    modport sink   (input valid, centered, out_point, output ready);

endinterface

>>> hw/rtl/smc_ram.sv
module smc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/snapshot_mean_centering.sv
// Accumulate request: sum read, then written back; the next request is taken after that.
// Center request: 24-step restoring divide of |sum| by the clamped snapshot count, then
// subtract and saturate; the result is registered once the output register is free, and no
// new request is taken until then. The sum memory and the divider loop set this pacing.
// Reset: asynchronous, active low; snapshot_count returns to 1 and a clearing pass
// zeroes the sum memory, one entry a cycle, with no request taken.
module snapshot_mean_centering import smc_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    smc_item_if.sink         item,
    smc_result_if.source     result
);

    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int EXT_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int DIFF_W  = SUM_W + 2;

    // Sequencer codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Request held while it is worked on
    logic                       action_reg;
    logic                       first_reg;
    logic                       in_range_reg;
    logic [IDX_W-1:0]           point_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    // Divider
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsor_reg, dsor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;

    // Output stage
    logic                     out_valid_reg, out_valid_next;
    logic signed [CENT_W-1:0] out_cent_reg, out_cent_next;
    logic [IDX_W-1:0]         out_point_reg;

    logic              accept;
    logic [EXT_W-1:0]  idx_ext;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  sample_ext;
    logic [SUM_W-1:0]  sum_used;
    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic signed [DIFF_W-1:0] mean_s;
    logic signed [DIFF_W-1:0] diff;
    logic              out_free;

    assign item.ready    = (state_reg == S_IDLE);
    assign accept        = item.valid && item.ready;
    assign idx_ext       = EXT_W'(item.point_index);

    assign result.valid     = out_valid_reg;
    assign result.centered  = out_cent_reg;
    assign result.out_point = out_point_reg;

    smc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_POINTS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign sample_ext = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};

    // Write port: clearing pass, else accumulate write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = first_reg ? sample_ext : (ram_rdata + sample_ext);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_LOAD && action_reg == ACTION_ACCUM && in_range_reg)
        begin
            ram_we = 1'b1;
        end
    end

    // Clamp the snapshot count into a usable divisor
    always_comb
    begin
        if (count_reg == '0)
        begin
            divisor = CNT_W'(1);
        end
        else if (32'(count_reg) > MAX_SNAPSHOTS)
        begin
            divisor = CNT_W'(MAX_SNAPSHOTS);
        end
        else
        begin
            divisor = count_reg;
        end
    end

    assign sum_used = in_range_reg ? ram_rdata : '0;
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, dsor_reg});

    assign mean_s   = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign diff     = $signed({{(DIFF_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg}) - mean_s;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = cfg_we ? cfg_wdata : count_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dsor_next      = dsor_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_cent_next  = out_cent_reg;

        if (diff > $signed(DIFF_W'(CENT_LIMIT)))
        begin
            out_cent_next = CENT_W'(CENT_LIMIT);
        end
        else if (diff < -$signed(DIFF_W'(CENT_LIMIT)))
        begin
            out_cent_next = -$signed(CENT_W'(CENT_LIMIT));
        end
        else
        begin
            out_cent_next = diff[CENT_W-1:0];
        end
        if (state_reg != S_OUT || !out_free)
        begin
            out_cent_next = out_cent_reg;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_POINTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (action_reg == ACTION_ACCUM)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    // Divide the magnitude; fix the sign at the end
                    neg_next   = sum_used[SUM_W-1];
                    quo_next   = sum_used[SUM_W-1] ? -sum_used : sum_used;
                    rem_next   = '0;
                    dsor_next  = divisor;
                    step_next  = STEP_W'(SUM_W);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = q_bit ? CNT_W'(trial - {1'b0, dsor_reg}) : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], q_bit};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= CNT_W'(1);
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= item.action;
            first_reg    <= item.first_snapshot;
            in_range_reg <= (32'(item.point_index) < MAX_POINTS);
            point_reg    <= item.point_index;
            addr_reg     <= idx_ext[ADDR_W-1:0];
            sample_reg   <= item.sample;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_point_reg <= point_reg;
        end
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dsor_reg     <= dsor_next;
        neg_reg      <= neg_next;
        out_cent_reg <= out_cent_next;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for snapshot_mean_centering.
//
// Accumulate requests build a per-point sum and produce nothing.
// Center requests return the sample minus that point's mean.
// A local model keeps its own copy of the sums and of snapshot_count.
// Each accepted center request pushes one expected result.
// A checker on the result channel pops and compares each result field by field.
module tb;

    import smc_pkg::*;

    // Long enough to cover an accumulate or a center request still in flight
    // once the last result is out.
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [CENT_W-1:0] centered;
        logic [IDX_W-1:0]         point;
    } centered_sample_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             recv_ready = 1'b0;

    smc_item_if   item_ch ();
    smc_result_if result_ch ();

    assign result_ch.ready = recv_ready;

    snapshot_mean_centering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch.sink),
        .result    (result_ch.source)
    );

    // Model state: per-point sums (24-bit wrap) and the snapshot_count register.
    logic signed [SUM_W-1:0] sum_model [DEF_MAX_POINTS];
    logic [CNT_W-1:0]        count_model;

    // Expected center results, oldest first.
    centered_sample_t        pending_centered [$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure. Change ready only at the falling edge.
    always @(negedge clk)
    begin
        recv_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string field, logic [IDX_W-1:0] pt, int got, int want);
        $display("mismatch in %s (point %0d): got %0d, want %0d", field, pt, got, want);
        error_count++;
    endtask

    // Apply one accepted request to the model.
    // A center request pushes its expected result.
    function automatic void predict_request(logic act, logic first, logic [IDX_W-1:0] pt,
                                            logic signed [SAMPLE_W-1:0] s);
        int               divisor;
        int               mean;
        int               diff;
        centered_sample_t res;
        if (act == ACTION_ACCUM)
        begin
            // Out-of-range points leave the sums alone.
            if (pt < DEF_MAX_POINTS)
            begin
                if (first)
                    sum_model[pt] = SUM_W'(s);
                else
                    sum_model[pt] = sum_model[pt] + SUM_W'(s);
            end
        end
        else
        begin
            // Clamp the divisor: zero divides by one, and values above the
            // snapshot limit divide by the limit.
            if (count_model == 0)
                divisor = 1;
            else if (count_model > MAX_SNAPSHOTS)
                divisor = MAX_SNAPSHOTS;
            else
                divisor = int'(count_model);
            // Integer division truncates toward zero, as the block does.
            mean = (pt < DEF_MAX_POINTS) ? int'(sum_model[pt]) / divisor : 0;
            diff = int'(s) - mean;
            if (diff > CENT_LIMIT)
                diff = CENT_LIMIT;
            if (diff < -CENT_LIMIT)
                diff = -CENT_LIMIT;
            res.centered = diff[CENT_W-1:0];
            res.point    = pt;
            pending_centered.push_back(res);
        end
    endfunction

    // Send one request. Enter and leave on a falling edge.
    // Leave valid high so that a back-to-back request never lowers it and raises it
    // again in the same step.
    task automatic send_request(logic act, logic first, logic [IDX_W-1:0] pt,
                                logic signed [SAMPLE_W-1:0] s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.action         <= act;
        item_ch.first_snapshot <= first;
        item_ch.point_index    <= pt;
        item_ch.sample         <= s;
        // Hold the request until the block takes it. This also covers the clearing pass after reset.
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_request(act, first, pt, s);
        @(negedge clk);
    endtask

    // Drop valid, then wait until every expected result is back and
    // trailing accumulates have settled.
    task automatic drain;
        item_ch.valid <= 1'b0;
        while (pending_centered.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write snapshot_count. Write only while the block is idle.
    task automatic set_snapshot_count(logic [CNT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        count_model = value;
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // Check each result as it is taken, against the oldest expectation.
    always @(posedge clk)
    begin
        centered_sample_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_centered.size() == 0)
            begin
                report_mismatch("unexpected result", result_ch.out_point,
                                int'(result_ch.centered), 0);
            end
            else
            begin
                want = pending_centered.pop_front();
                if (result_ch.centered !== want.centered)
                    report_mismatch("centered", want.point, int'(result_ch.centered),
                                    int'(want.centered));
                if (result_ch.out_point !== want.point)
                    report_mismatch("out_point", want.point, int'(result_ch.out_point),
                                    int'(want.point));
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            default: return SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    // After reset every sum is zero, so the sample comes back unchanged.
    // The first flag has no effect in the center pass.
    task automatic test_cleared_sums;
        send_request(ACTION_CENTER, 1'b0, 10'd0, -16'sd32768);
        send_request(ACTION_CENTER, 1'b1, 10'd1023, 16'sd32767);
        send_request(ACTION_CENTER, 1'b0, 10'd512, 16'sd1);
        drain();
    endtask

    // Load, add and reload. Back-to-back requests to one point read each sum
    // right after its write-back.
    task automatic test_load_and_accumulate;
        send_request(ACTION_ACCUM, 1'b1, 10'd1023, 16'sd100);
        send_request(ACTION_ACCUM, 1'b0, 10'd1023, -16'sd30);
        send_request(ACTION_ACCUM, 1'b0, 10'd1023, 16'sd7);
        send_request(ACTION_CENTER, 1'b0, 10'd1023, 16'sd0);
        send_request(ACTION_ACCUM, 1'b1, 10'd1023, -16'sd5);
        send_request(ACTION_CENTER, 1'b1, 10'd1023, 16'sd10);
        send_request(ACTION_ACCUM, 1'b0, 10'd0, 16'sd21);
        send_request(ACTION_CENTER, 1'b0, 10'd0, -16'sd1);
        drain();
    endtask

    // With divisor one, a doubled extreme sum drives the difference past
    // the 17-bit limit both ways. It also lands exactly on the limit.
    task automatic test_saturation;
        set_snapshot_count(9'd1);
        send_request(ACTION_ACCUM, 1'b1, 10'd3, 16'sd32767);
        send_request(ACTION_ACCUM, 1'b0, 10'd3, 16'sd32767);
        send_request(ACTION_CENTER, 1'b0, 10'd3, -16'sd32768);
        send_request(ACTION_ACCUM, 1'b1, 10'd4, -16'sd32768);
        send_request(ACTION_ACCUM, 1'b0, 10'd4, -16'sd32768);
        send_request(ACTION_CENTER, 1'b0, 10'd4, 16'sd32767);
        send_request(ACTION_ACCUM, 1'b1, 10'd5, -16'sd32768);
        send_request(ACTION_CENTER, 1'b0, 10'd5, 16'sd32767);
        drain();
    endtask

    // Zero divides by one. Values above the snapshot limit divide by the
    // limit. Negative sums truncate toward zero.
    task automatic test_divisor_limits;
        set_snapshot_count(9'd0);
        send_request(ACTION_ACCUM, 1'b1, 10'd10, -16'sd7);
        send_request(ACTION_CENTER, 1'b0, 10'd10, 16'sd0);
        set_snapshot_count(9'd2);
        send_request(ACTION_CENTER, 1'b0, 10'd10, 16'sd0);
        set_snapshot_count(9'd511);
        send_request(ACTION_ACCUM, 1'b1, 10'd11, 16'sd32767);
        send_request(ACTION_ACCUM, 1'b0, 10'd11, 16'sd32767);
        send_request(ACTION_CENTER, 1'b0, 10'd11, 16'sd0);
        set_snapshot_count(9'd257);
        send_request(ACTION_CENTER, 1'b0, 10'd11, -16'sd1);
        set_snapshot_count(9'd256);
        send_request(ACTION_CENTER, 1'b0, 10'd10, 16'sd0);
        drain();
    endtask

    // 257 maximal samples overflow the 24-bit sum, which must wrap.
    task automatic test_sum_wrap;
        set_snapshot_count(9'd256);
        send_request(ACTION_ACCUM, 1'b1, 10'd7, 16'sd32767);
        for (int n = 0; n < 256; n++)
            send_request(ACTION_ACCUM, 1'b0, 10'd7, 16'sd32767);
        send_request(ACTION_CENTER, 1'b0, 10'd7, 16'sd0);
        set_snapshot_count(9'd1);
        send_request(ACTION_CENTER, 1'b0, 10'd7, 16'sd32767);
        drain();
    endtask

    // Random phase. Most of the stimulus is well-formed: pick a snapshot
    // count and a few points, accumulate the snapshots with the first flag
    // on the opening one, then center them. About one request in ten is
    // noise with fully random fields.
    task automatic run_random_phase(int sender_pct, int receiver_pct, int budget);
        int               sent;
        int               pick;
        int               n_snap;
        int               n_pts;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] pts [$];
        sent = 0;
        set_idling(sender_pct, receiver_pct);
        while (sent < budget)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                cnt = '0;
            else if (pick == 1)
                cnt = CNT_W'($urandom_range(511, 257));
            else if (pick == 2)
                cnt = CNT_W'(MAX_SNAPSHOTS);
            else
                cnt = CNT_W'($urandom_range(1, 8));
            set_snapshot_count(cnt);
            n_snap = (cnt >= 1 && cnt <= 8) ? int'(cnt) : $urandom_range(1, 8);
            n_pts  = $urandom_range(1, 6);
            pts.delete();
            for (int p = 0; p < n_pts; p++)
                pts.push_back(IDX_W'($urandom_range(DEF_MAX_POINTS - 1)));
            for (int pass = 0; pass < 2; pass++)
            begin
                for (int sn = 0; sn < n_snap; sn++)
                begin
                    for (int p = 0; p < n_pts; p++)
                    begin
                        if ($urandom_range(9) == 0)
                        begin
                            send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                                         IDX_W'($urandom_range(DEF_MAX_POINTS - 1)),
                                         random_sample());
                            sent++;
                        end
                        if (pass == 0)
                            send_request(ACTION_ACCUM, sn == 0, pts[p], random_sample());
                        else
                            send_request(ACTION_CENTER, 1'($urandom_range(1)), pts[p],
                                         random_sample());
                        sent++;
                    end
                end
            end
        end
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < DEF_MAX_POINTS; i++)
            sum_model[i] = '0;
        count_model            = 9'd1;
        item_ch.valid          = 1'b0;
        item_ch.action         = ACTION_ACCUM;
        item_ch.first_snapshot = 1'b0;
        item_ch.point_index    = '0;
        item_ch.sample         = '0;

        // Hold reset, then release it on a falling edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_sums();
        test_load_and_accumulate();
        test_saturation();
        test_divisor_limits();
        test_sum_wrap();

        run_random_phase(0, 0, 60);
        run_random_phase(80, 0, 60);
        run_random_phase(0, 80, 60);
        run_random_phase(28, 28, 60);

        set_idling(0, 0);
        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Timeout. A correct run finishes long before this.
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
